// File: src/rrip_pkg.sv
// ----------------------------------------------------------------------------
// rrip_pkg
// Shared types and constants for the RRIP replacement block.
// ----------------------------------------------------------------------------
package rrip_pkg;

    localparam logic [1:0] RRPV_MAX     = 2'd3;
    localparam logic [1:0] REUSE_MAX    = 2'd3;
    localparam logic [1:0] REUSE_STRONG = 2'd2;
    localparam logic [1:0] REUSE_INIT   = 2'd1;
    localparam int         SIG_SHIFT    = 5;
    localparam logic [2:0] STRIDE_MAX   = 3'd7;
    localparam logic [2:0] THRESH_RESET = 3'd5;

    localparam logic CMD_VICTIM = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic execute;
        logic out_load;
    } ctrl_t;

    typedef struct packed {
        logic clear_done;
        logic is_victim;
    } stat_t;

endpackage

// File: src/rrip_if.sv
// ----------------------------------------------------------------------------
// rrip_if
// Valid/ready channels for requests, results and configuration.
// ----------------------------------------------------------------------------
interface rrip_req_if #(
    parameter int SET_W = 11,
    parameter int WAY_W = 4,
    parameter int MASK_W = 16
);
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [SET_W-1:0]  set_index;
    logic [WAY_W-1:0]  way_index;
    logic [63:0]       phys_addr;
    logic [63:0]       prog_counter;
    logic              was_hit;
    logic [MASK_W-1:0] valid_mask;
    modport source (output valid, cmd, set_index, way_index, phys_addr, prog_counter,
                    was_hit, valid_mask, input ready);
    modport sink (input valid, cmd, set_index, way_index, phys_addr, prog_counter,
                  was_hit, valid_mask, output ready);
endinterface

interface rrip_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] victim_way;
    logic       took_invalid;
    modport source (output valid, victim_way, took_invalid, input ready);
    modport sink (input valid, victim_way, took_invalid, output ready);
endinterface

interface rrip_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// File: src/rrip_ctrl.sv
// ----------------------------------------------------------------------------
// rrip_ctrl
// Sequencer: clearing pass, read, execute, result handoff.
// ----------------------------------------------------------------------------
module rrip_ctrl
    import rrip_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output ctrl_t ctrl
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (stat.clear_done) state_next = ST_IDLE;
            ST_IDLE:  if (in_valid) state_next = ST_READ;
            ST_READ:  state_next = ST_EXEC;
            ST_EXEC:  state_next = stat.is_victim ? ST_OUT : ST_IDLE;
            ST_OUT:   if (out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_CLEAR: ctrl.clear_step = 1'b1;
            ST_IDLE:
            begin
                in_ready = 1'b1;
                ctrl.capture = in_valid;
            end
            ST_READ:  ;
            ST_EXEC:
            begin
                ctrl.execute = 1'b1;
                ctrl.out_load = stat.is_victim;
            end
            ST_OUT:   out_valid = 1'b1;
            default:  ;
        endcase
    end
endmodule

// File: src/rrip_dp.sv
// ----------------------------------------------------------------------------
// rrip_dp
// Metadata memories, aging/victim search, reuse and stride update.
// ----------------------------------------------------------------------------
module rrip_dp
    import rrip_pkg::*;
#(
    parameter int NUM_SETS = 2048,
    parameter int NUM_WAYS = 16,
    parameter int SIG_WIDTH = 5
)(
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_t       ctrl,
    output stat_t       stat,
    input  logic        cmd,
    input  logic [10:0] set_index,
    input  logic [3:0]  way_index,
    input  logic [63:0] phys_addr,
    input  logic [63:0] prog_counter,
    input  logic        was_hit,
    input  logic [15:0] valid_mask,
    input  logic [2:0]  threshold,
    output logic [3:0]  victim_way,
    output logic        took_invalid
);
    localparam int SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int RW = SW + SIG_WIDTH;
    localparam int WW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int CW = (RW > SW) ? RW : SW;
    localparam int CLR_LAST = (NUM_SETS << SIG_WIDTH) - 1;
    // reciprocal of the set count, exact for any 11-bit set number
    localparam longint SET_RECIP = ((longint'(1) << 27) + NUM_SETS - 1) / NUM_SETS;

    logic [2*NUM_WAYS-1:0] rrpv_mem [NUM_SETS];
    logic [1:0]            reuse_mem [NUM_SETS << SIG_WIDTH];
    logic [63:0]           addr_mem [NUM_SETS];
    logic [63:0]           delta_mem [NUM_SETS];
    logic [2:0]            stride_mem [NUM_SETS];

    logic [CW-1:0] clr_reg;
    logic          clr_done_reg;

    logic              cmd_reg;
    logic [SW-1:0]     set_reg;
    logic [3:0]        way_reg;
    logic [63:0]       addr_reg;
    logic [SIG_WIDTH-1:0] sig_reg;
    logic              hit_reg;
    logic [15:0]       mask_reg;

    logic [2*NUM_WAYS-1:0] rrpv_rd_reg;
    logic [1:0]            reuse_rd_reg;
    logic [63:0]           paddr_rd_reg;
    logic [63:0]           pdelta_rd_reg;
    logic [2:0]            stride_rd_reg;

    logic [3:0] vway_reg;
    logic       tinv_reg;

    logic [SW-1:0] set_in;
    logic [37:0]   set_prod;
    logic [10:0]   set_quo;
    logic [63:0]   pc_mix;
    logic [RW-1:0] ridx;

    assign set_prod = 38'(set_index) * 38'(SET_RECIP);
    assign set_quo  = set_prod[37:27];
    assign set_in = SW'(32'(set_index) - 32'(set_quo) * 32'(NUM_SETS));
    assign pc_mix = prog_counter ^ (prog_counter >> SIG_SHIFT);
    assign ridx = {set_reg, sig_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            clr_done_reg <= 1'b0;
        end
        else if (ctrl.clear_step && !clr_done_reg)
        begin
            if (clr_reg == CW'(CLR_LAST))
            begin
                clr_done_reg <= 1'b1;
            end
            clr_reg <= clr_reg + 1'b1;
        end
    end

    assign stat.clear_done = clr_done_reg || (ctrl.clear_step && clr_reg == CW'(CLR_LAST));
    assign stat.is_victim  = (cmd_reg == CMD_VICTIM);

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg  <= cmd;
            set_reg  <= set_in;
            way_reg  <= way_index;
            addr_reg <= phys_addr;
            sig_reg  <= pc_mix[SIG_WIDTH-1:0];
            hit_reg  <= was_hit;
            mask_reg <= valid_mask;
        end
        rrpv_rd_reg   <= rrpv_mem[set_reg];
        reuse_rd_reg  <= reuse_mem[ridx];
        paddr_rd_reg  <= addr_mem[set_reg];
        pdelta_rd_reg <= delta_mem[set_reg];
        stride_rd_reg <= stride_mem[set_reg];
    end

    // victim search and aging
    logic          any_inv;
    logic [WW-1:0] inv_way;
    logic [1:0]    top;
    logic [1:0]    add;
    logic [2*NUM_WAYS-1:0] aged;
    logic [WW-1:0] age_way;
    logic          age_found;

    always_comb
    begin
        any_inv = 1'b0;
        inv_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (w < 16 && !mask_reg[w % 16])
            begin
                any_inv = 1'b1;
                inv_way = WW'(w);
            end
        end
        top = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (rrpv_rd_reg[2*w +: 2] > top) top = rrpv_rd_reg[2*w +: 2];
        end
        add = RRPV_MAX - top;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            aged[2*w +: 2] = rrpv_rd_reg[2*w +: 2] + add;
        end
        age_found = 1'b0;
        age_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (aged[2*w +: 2] == RRPV_MAX)
            begin
                age_found = 1'b1;
                age_way = WW'(w);
            end
        end
    end

    // stride detector and update values
    logic [63:0] delta;
    logic [2:0]  stride_new;
    logic        streaming;
    logic [1:0]  ins;
    logic [1:0]  reuse_new;
    logic        way_ok;
    logic [2*NUM_WAYS-1:0] blk_upd;

    always_comb
    begin
        delta = addr_reg - paddr_rd_reg;
        if (paddr_rd_reg == '0)
            stride_new = '0;
        else if (delta == pdelta_rd_reg && delta != '0)
            stride_new = (stride_rd_reg < STRIDE_MAX) ? stride_rd_reg + 3'd1 : stride_rd_reg;
        else
            stride_new = (stride_rd_reg > 3'd0) ? stride_rd_reg - 3'd1 : stride_rd_reg;
        streaming = stride_new >= threshold;
        ins = (reuse_rd_reg >= REUSE_STRONG && !streaming) ? 2'd0 : RRPV_MAX;
        if (hit_reg)
            reuse_new = (reuse_rd_reg < REUSE_MAX) ? reuse_rd_reg + 2'd1 : reuse_rd_reg;
        else
            reuse_new = REUSE_INIT;
        way_ok = 32'(way_reg) < NUM_WAYS;
        blk_upd = rrpv_rd_reg;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (way_ok && 32'(way_reg) == w) blk_upd[2*w +: 2] = hit_reg ? 2'd0 : ins;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.clear_step && !clr_done_reg)
        begin
            reuse_mem[clr_reg[RW-1:0]] <= REUSE_INIT;
            if (clr_reg < CW'(NUM_SETS))
            begin
                rrpv_mem[clr_reg[SW-1:0]]   <= {NUM_WAYS{RRPV_MAX}};
                addr_mem[clr_reg[SW-1:0]]   <= '0;
                delta_mem[clr_reg[SW-1:0]]  <= '0;
                stride_mem[clr_reg[SW-1:0]] <= '0;
            end
        end
        else if (ctrl.execute)
        begin
            if (cmd_reg == CMD_VICTIM)
            begin
                if (!any_inv) rrpv_mem[set_reg] <= aged;
            end
            else
            begin
                rrpv_mem[set_reg]   <= blk_upd;
                reuse_mem[ridx]     <= reuse_new;
                addr_mem[set_reg]   <= addr_reg;
                delta_mem[set_reg]  <= delta;
                stride_mem[set_reg] <= stride_new;
            end
        end
        if (ctrl.out_load)
        begin
            vway_reg <= any_inv ? 4'(inv_way) : (age_found ? 4'(age_way) : 4'(NUM_WAYS));
            tinv_reg <= any_inv;
        end
    end

    assign victim_way   = vway_reg;
    assign took_invalid = tinv_reg;
endmodule

// File: src/rrip_replacement_with_stream_detect.sv
// ----------------------------------------------------------------------------
// rrip_replacement_with_stream_detect
// SRRIP replacement with per-signature reuse counters and stride detection.
// ----------------------------------------------------------------------------
// channel | dir | payload
// req     | in  | cmd, set_index, way_index, phys_addr, prog_counter, was_hit, valid_mask
// rsp     | out | victim_way, took_invalid (victim requests only)
// cfg     | in  | data = streaming threshold
// Each request passes through accept, memory read and execute; a victim result
// then waits in its output register until its transfer.
// After reset a clearing pass over all NUM_SETS << SIG_WIDTH reuse entries (65536
// at defaults) runs with req.ready low; cfg writes are always taken.
// ----------------------------------------------------------------------------
module rrip_replacement_with_stream_detect
    import rrip_pkg::*;
#(
    parameter int NUM_SETS = 2048,
    parameter int NUM_WAYS = 16,
    parameter int SIG_WIDTH = 5
)(
    input logic clk,
    input logic rst_n,
    rrip_req_if.sink   req,
    rrip_rsp_if.source rsp,
    rrip_cfg_if.sink   cfg
);
    ctrl_t ctrl;
    stat_t stat;
    logic [2:0] thresh_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg.valid)
        begin
            thresh_reg <= cfg.data;
        end
    end

    rrip_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_ready(req.ready),
        .out_valid(rsp.valid), .out_ready(rsp.ready),
        .stat(stat), .ctrl(ctrl)
    );

    rrip_dp #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .SIG_WIDTH(SIG_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .stat(stat),
        .cmd(req.cmd), .set_index(req.set_index), .way_index(req.way_index),
        .phys_addr(req.phys_addr), .prog_counter(req.prog_counter),
        .was_hit(req.was_hit), .valid_mask(req.valid_mask),
        .threshold(thresh_reg),
        .victim_way(rsp.victim_way), .took_invalid(rsp.took_invalid)
    );

    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !req.ready) else $error("request taken while result pending");
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.victim_way))
        else $error("result dropped");
    a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready) else $error("back-to-back accept");
endmodule

// File: test/rrip_tb_if.sv
// ----------------------------------------------------------------------------
// rrip_tb_if
// Testbench scoreboard package for the block's channel interfaces (see src/rrip_if.sv).
// ----------------------------------------------------------------------------
// Interfaces are taken from the RTL package file set; this file holds the
// scoreboard class shared by the top module.
// ----------------------------------------------------------------------------
package rrip_tb_pkg;

    typedef struct {
        logic [3:0] victim_way;
        logic       took_invalid;
    } victim_t;

    class victim_scoreboard;
        logic [1:0]  reref  [2048][16];
        logic [1:0]  reuse  [2048][32];
        logic [63:0] seen_addr  [2048];
        logic [63:0] seen_delta [2048];
        logic [2:0]  stride [2048];
        logic [2:0]  threshold;
        victim_t     pending[$];
        int          errors;
        int          checked;

        function void reset_state();
            foreach (reref[s, w]) reref[s][w] = 2'd3;
            foreach (reuse[s, g]) reuse[s][g] = 2'd1;
            foreach (seen_addr[s])
            begin
                seen_addr[s]  = '0;
                seen_delta[s] = '0;
                stride[s]     = '0;
            end
            threshold = 3'd5;
            errors    = 0;
            checked   = 0;
        endfunction

        function void note_request(logic cmd, logic [10:0] set_i, logic [3:0] way,
                                   logic [63:0] addr, logic [63:0] pc, logic hit,
                                   logic [15:0] mask);
            logic [1:0]  top;
            logic [1:0]  ins;
            logic [4:0]  sig;
            logic [63:0] delta;
            victim_t     r;
            int          w;
            if (cmd == 1'b0)
            begin
                for (w = 0; w < 16; w++)
                    if (!mask[w])
                        break;
                if (w < 16)
                begin
                    r.victim_way   = w[3:0];
                    r.took_invalid = 1'b1;
                end
                else
                begin
                    top = 0;
                    for (w = 0; w < 16; w++)
                        if (reref[set_i][w] > top)
                            top = reref[set_i][w];
                    for (w = 0; w < 16; w++)
                        reref[set_i][w] = reref[set_i][w] + (2'd3 - top);
                    for (w = 0; w < 16; w++)
                        if (reref[set_i][w] == 2'd3)
                            break;
                    r.victim_way   = w[3:0];
                    r.took_invalid = 1'b0;
                end
                pending.push_back(r);
            end
            else
            begin
                sig   = pc[4:0] ^ pc[9:5];
                delta = addr - seen_addr[set_i];
                if (seen_addr[set_i] == 0)
                    stride[set_i] = 0;
                else if (delta == seen_delta[set_i] && delta != 0)
                begin
                    if (stride[set_i] != 3'd7)
                        stride[set_i]++;
                end
                else if (stride[set_i] != 0)
                    stride[set_i]--;
                seen_delta[set_i] = delta;
                seen_addr[set_i]  = addr;
                if (hit)
                begin
                    reref[set_i][way] = 0;
                    if (reuse[set_i][sig] != 2'd3)
                        reuse[set_i][sig]++;
                end
                else
                begin
                    ins = (reuse[set_i][sig] >= 2'd2) ? 2'd0 : 2'd3;
                    if (stride[set_i] >= threshold)
                        ins = 2'd3;
                    reref[set_i][way] = ins;
                    reuse[set_i][sig] = 2'd1;
                end
            end
        endfunction

        function void check_result(logic [3:0] way, logic inv);
            victim_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result: victim_way=%0d took_invalid=%0d", way, inv);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (e.victim_way !== way)
            begin
                $error("victim_way: expected %0d, got %0d", e.victim_way, way);
                errors++;
            end
            if (e.took_invalid !== inv)
            begin
                $error("took_invalid: expected %0d, got %0d", e.took_invalid, inv);
                errors++;
            end
        endfunction
    endclass

endpackage

// File: test/rrip_replacement_with_stream_detect_tb.sv
// ----------------------------------------------------------------------------
// rrip_replacement_with_stream_detect_tb
// Self-checking bench for the RRIP victim selector with stream detection.
// Drives directed and random victim/update traffic over several threshold
// settings and idle patterns, predicting every victim result in a scoreboard.
// ----------------------------------------------------------------------------
module rrip_replacement_with_stream_detect_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rrip_pkg::*;
    import rrip_tb_pkg::*;

    localparam int STALL_LIMIT = 200000;

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   dst_stall_pct;
    bit   hold_off;
    bit   timed_out;
    int   quiet_cycles;
    int   n_sent;
    int   n_victim;

    rrip_req_if req ();
    rrip_rsp_if rsp ();
    rrip_cfg_if cfg ();

    victim_scoreboard sb;

    rrip_replacement_with_stream_detect u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // note transfers and check results at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (req.valid && req.ready)
                sb.note_request(req.cmd, req.set_index, req.way_index, req.phys_addr,
                                req.prog_counter, req.was_hit, req.valid_mask);
            if (rsp.valid && rsp.ready)
                sb.check_result(rsp.victim_way, rsp.took_invalid);
        end
    end

    always @(negedge clk)
    begin
        rsp.ready <= !hold_off && ($urandom_range(99) >= dst_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && quiet_cycles > STALL_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send(logic cmd, logic [10:0] set_i, logic [3:0] way,
                        logic [63:0] addr, logic [63:0] pc, logic hit, logic [15:0] mask);
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid        <= 1'b1;
        req.cmd          <= cmd;
        req.set_index    <= set_i;
        req.way_index    <= way;
        req.phys_addr    <= addr;
        req.prog_counter <= pc;
        req.was_hit      <= hit;
        req.valid_mask   <= mask;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
        n_sent++;
        if (cmd == CMD_VICTIM)
            n_victim++;
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_threshold(logic [2:0] value);
        drain();
        cfg.valid <= 1'b1;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        sb.threshold = value;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // one random item; mostly sets from a small pool, strided addresses
    task automatic random_item(int pool);
        logic [10:0] set_i;
        logic [63:0] addr;
        logic [15:0] mask;
        set_i = (pool > 0) ? 11'($urandom_range(pool - 1)) : 11'($urandom);
        if ($urandom_range(3) == 0)
            addr = rand64();
        else
            addr = sb.seen_addr[set_i] + 64'(64 * ($urandom_range(2) + 1));
        case ($urandom_range(3))
            0: mask = 16'hFFFF;
            1: mask = 16'($urandom);
            2: mask = ~(16'h1 << $urandom_range(15));
            default: mask = 16'hFFFF;
        endcase
        if ($urandom_range(1) == 0)
            send(CMD_VICTIM, set_i, 4'($urandom), rand64(), rand64(), 1'($urandom), mask);
        else
            send(CMD_UPDATE, set_i, 4'($urandom), addr,
                 64'($urandom_range(7)) ^ (($urandom_range(3) == 0) ? rand64() : 64'h0),
                 1'($urandom), 16'($urandom));
    endtask

    initial
    begin
        logic [2:0] thresholds [4] = '{3'd0, 3'd7, 3'd2, 3'd5};
        int         idle_src [4] = '{0, 57, 0, 37};
        int         idle_dst [4] = '{0, 0, 57, 37};
        sb = new();
        sb.reset_state();
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.cmd = CMD_VICTIM;
        req.set_index = '0;
        req.way_index = '0;
        req.phys_addr = '0;
        req.prog_counter = '0;
        req.was_hit = 1'b0;
        req.valid_mask = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        hold_off = 1'b0;
        timed_out = 1'b0;
        quiet_cycles = 0;
        src_idle_pct = 0;
        dst_stall_pct = 0;
        n_sent = 0;
        n_victim = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, both commands, invalid vs aged pick, strides
        send(CMD_VICTIM, 11'd0, 4'd0, '0, '0, 1'b0, 16'h0000);
        send(CMD_VICTIM, 11'd2047, 4'd15, '1, '1, 1'b1, 16'h7FFF);
        send(CMD_VICTIM, 11'd5, 4'd0, '0, '0, 1'b0, 16'hFFFF);
        send(CMD_UPDATE, 11'd5, 4'd3, 64'h100, 64'h21, 1'b1, 16'hFFFF);
        send(CMD_UPDATE, 11'd5, 4'd3, 64'h140, 64'h21, 1'b1, 16'h0);
        send(CMD_UPDATE, 11'd5, 4'd7, 64'h180, 64'h21, 1'b0, 16'h0);
        send(CMD_VICTIM, 11'd5, 4'd0, '0, '0, 1'b0, 16'hFFFF);
        send(CMD_VICTIM, 11'd5, 4'd0, '0, '0, 1'b0, 16'hFFFF);
        for (int i = 0; i < 6; i++)
            send(CMD_UPDATE, 11'd9, 4'(i), 64'h1000 + 64'(i * 64), '1, 1'b0, '0);
        send(CMD_UPDATE, 11'd2047, 4'd15, '1, '1, 1'b1, '1);
        send(CMD_UPDATE, 11'd2047, 4'd0, '0, '0, 1'b0, '0);
        send(CMD_VICTIM, 11'd9, 4'd0, '0, '0, 1'b0, 16'hFFFF);
        send(CMD_VICTIM, 11'd2047, 4'd0, '0, '0, 1'b0, 16'h8000);

        // receiver holds off while the sender keeps pushing
        drain();
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 12; i++)
                    random_item(4);
                req.valid <= 1'b0;
            end
        join

        for (int ph = 0; ph < 4; ph++)
        begin
            write_threshold(thresholds[ph]);
            src_idle_pct = idle_src[ph];
            dst_stall_pct = idle_dst[ph];
            for (int i = 0; i < 380; i++)
                random_item((i % 5 == 4) ? 0 : 16);
        end
        src_idle_pct = 0;
        dst_stall_pct = 0;
        drain();
        repeat (10) @(negedge clk);
        $display("Sent %0d requests (%0d victim), checked %0d results, 4 thresholds",
                 n_sent, n_victim, sb.checked);
        $display("across idle, sender-gap, receiver-stall and mixed phases.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
